@@ rtl/dttf_pkg.sv @@
// ----------------------------------------------------------------------------
// dttf_pkg
// Types and character constants shared by the decimal text parser modules.
// ----------------------------------------------------------------------------
package dttf_pkg;

    localparam int RES_BITS = 64;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [1:0] CFG_DECIMAL = 2'd0;
    localparam logic [1:0] CFG_FRAC    = 2'd1;
    localparam logic [1:0] CFG_SIGNED  = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       string_end;
    } t_req;

    typedef struct packed {
        logic [RES_BITS-1:0] value;
        logic                overflow;
    } t_res;

    typedef struct packed {
        logic       digit_en;
        logic       round_en;
        logic       last;
        logic [3:0] digit;
        logic [4:0] pad;
        logic       negative;
    } t_op;

endpackage

@@ rtl/decimal_text_to_fixed_point.sv @@
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Parses an ASCII decimal string, one character per request, into a
// saturating fixed-point value with a configurable number of fraction digits.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the operation queue is not full;
//   a string end makes the accumulator pad the missing fraction digits with
//   zeros before it registers the result, and it takes no new operations
//   until the result is written.
// Reset: synchronous, clears parse state and queue, and restores the
//   configuration to decimal character 46, three fraction digits, unsigned.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point #(
    parameter int VALUE_BITS  = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [7:0]     i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dttf_pkg::t_req i_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dttf_pkg::t_res o_res
);
    import dttf_pkg::*;

    logic full, push, q_valid, pop;
    t_op  push_op, q_op;

    dttf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req      (i_req),
        .i_full     (full),
        .o_push     (push),
        .o_op       (push_op)
    );

    dttf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    dttf_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .i_op        (q_op),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (o_res)
    );

endmodule

@@ rtl/dttf_front.sv @@
// ----------------------------------------------------------------------------
// dttf_front
// Configuration registers and the character classifier. Tracks the parse
// phase and issues accumulate, round and finish operations to the queue.
// ----------------------------------------------------------------------------
module dttf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  dttf_pkg::t_req    i_req,
    input  logic              i_full,
    output logic              o_push,
    output dttf_pkg::t_op     o_op
);
    import dttf_pkg::*;

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_INT    = 3'd2;
    localparam logic [2:0] PH_FRAC   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    logic [7:0] r_dec_char;
    logic [4:0] r_frac_digits;
    logic       r_signed_mode;

    logic [2:0] r_phase, n_phase;
    logic [4:0] r_frac_left, n_frac_left;
    logic       r_negative, n_negative;

    logic [7:0] c;
    logic       accept;
    logic       is_space, is_digit, is_dec, is_high;
    logic       dig_en, rnd_en;

    assign c        = i_req.char_code;
    assign accept   = i_in_valid && !o_in_stall;
    assign is_space = c inside {CH_SPACE, [CH_TAB:CH_CR]};
    assign is_digit = c inside {[CH_ZERO:CH_NINE]};
    assign is_high  = c inside {[CH_FIVE:CH_NINE]};
    assign is_dec   = (c == r_dec_char);

    assign o_in_stall = i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_char    <= 8'd46;
            r_frac_digits <= 5'd3;
            r_signed_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DECIMAL: r_dec_char    <= i_cfg_data;
                CFG_FRAC:    r_frac_digits <= i_cfg_data[4:0];
                CFG_SIGNED:  r_signed_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_frac_left = r_frac_left;
        n_negative  = r_negative;
        dig_en      = 1'b0;
        rnd_en      = 1'b0;
        case (r_phase)
            PH_LEAD, PH_SIGNED: begin
                if (r_phase == PH_LEAD) begin
                    n_frac_left = r_frac_digits;
                end
                if (is_space) begin
                    n_phase = r_phase;
                end else if (r_phase == PH_LEAD && r_signed_mode && c == CH_MINUS) begin
                    n_negative = 1'b1;
                    n_phase    = PH_SIGNED;
                end else if (c == CH_PLUS) begin
                    n_phase = PH_INT;
                end else if (is_digit) begin
                    dig_en  = 1'b1;
                    n_phase = PH_INT;
                end else if (is_dec) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    dig_en = 1'b1;
                end else if (is_dec) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_FRAC: begin
                if (r_frac_left != 5'd0) begin
                    if (is_digit) begin
                        dig_en      = 1'b1;
                        n_frac_left = r_frac_left - 5'd1;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end else begin
                    rnd_en  = is_high;
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    assign o_push         = accept && (dig_en || rnd_en || i_req.string_end);
    assign o_op.digit_en  = dig_en;
    assign o_op.round_en  = rnd_en;
    assign o_op.last      = i_req.string_end;
    assign o_op.digit     = 4'(c - CH_ZERO);
    assign o_op.pad       = n_frac_left;
    assign o_op.negative  = n_negative;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_frac_left <= 5'd0;
            r_negative  <= 1'b0;
        end else if (accept) begin
            if (i_req.string_end) begin
                r_phase     <= PH_LEAD;
                r_frac_left <= 5'd0;
                r_negative  <= 1'b0;
            end else begin
                r_phase     <= n_phase;
                r_frac_left <= n_frac_left;
                r_negative  <= n_negative;
            end
        end
    end

endmodule

@@ rtl/dttf_fifo.sv @@
// ----------------------------------------------------------------------------
// dttf_fifo
// Small register queue of operations between the classifier and the
// accumulator.
// ----------------------------------------------------------------------------
module dttf_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dttf_pkg::t_op  i_op,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output dttf_pkg::t_op  o_op
);
    import dttf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/dttf_back.sv @@
// ----------------------------------------------------------------------------
// dttf_back
// Accumulator: multiply by ten and add, rounding, zero padding of missing
// fraction digits, saturation, sign and the registered result.
// ----------------------------------------------------------------------------
module dttf_back #(
    parameter int VALUE_BITS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_op_valid,
    input  dttf_pkg::t_op  i_op,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dttf_pkg::t_res o_res
);
    import dttf_pkg::*;

    localparam int WB = VALUE_BITS + 4;

    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_ovf, n_ovf;
    logic                  r_fin, n_fin;
    logic                  r_neg, n_neg;
    logic [4:0]            r_pad, n_pad;
    logic                  r_out_valid, n_out_valid;
    t_res                  r_res, n_res;

    logic [WB-1:0]         acc_w, mul;
    logic [3:0]            add_digit;
    logic                  mul_ovf;
    logic                  do_finish;
    logic [VALUE_BITS-1:0] ones, res_v;

    assign ones      = '1;
    assign o_pop     = i_op_valid && !r_fin;
    assign add_digit = o_pop ? i_op.digit : 4'd0;
    assign acc_w     = WB'(r_acc);
    assign mul       = (acc_w << 3) + (acc_w << 1) + WB'(add_digit);
    assign mul_ovf   = |mul[WB-1:VALUE_BITS];
    assign do_finish = r_fin && (r_pad == 5'd0) && (!r_out_valid || !i_out_stall);

    always_comb begin
        if (r_ovf) begin
            res_v = ones;
        end else if (r_neg) begin
            res_v = '0 - r_acc;
        end else begin
            res_v = r_acc;
        end
    end

    always_comb begin
        n_acc       = r_acc;
        n_ovf       = r_ovf;
        n_fin       = r_fin;
        n_neg       = r_neg;
        n_pad       = r_pad;
        n_out_valid = r_out_valid && i_out_stall;
        n_res       = r_res;
        if (o_pop) begin
            if (i_op.digit_en && !r_ovf) begin
                if (mul_ovf) begin
                    n_acc = ones;
                    n_ovf = 1'b1;
                end else begin
                    n_acc = mul[VALUE_BITS-1:0];
                end
            end
            if (i_op.round_en && !r_ovf) begin
                if (r_acc == ones) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = r_acc + 1'b1;
                end
            end
            if (i_op.last) begin
                n_fin = 1'b1;
                n_pad = i_op.pad;
                n_neg = i_op.negative;
            end
        end else if (r_fin && r_pad != 5'd0) begin
            n_pad = r_pad - 5'd1;
            if (!r_ovf) begin
                if (mul_ovf) begin
                    n_acc = ones;
                    n_ovf = 1'b1;
                end else begin
                    n_acc = mul[VALUE_BITS-1:0];
                end
            end
        end else if (do_finish) begin
            n_out_valid                  = 1'b1;
            n_res.value                  = '0;
            n_res.value[VALUE_BITS-1:0]  = res_v;
            n_res.overflow               = r_ovf;
            n_acc                        = '0;
            n_ovf                        = 1'b0;
            n_neg                        = 1'b0;
            n_fin                        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_fin       <= 1'b0;
            r_neg       <= 1'b0;
            r_pad       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_ovf       <= n_ovf;
            r_fin       <= n_fin;
            r_neg       <= n_neg;
            r_pad       <= n_pad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    a_no_pop_while_finishing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> !o_pop)
        else $error("operation taken while a string is being finished");

    a_overflow_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && !do_finish) |=> r_ovf)
        else $error("overflow cleared before the result was written");

    a_pad_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin && r_pad != 5'd0) |=> (r_fin && r_pad == $past(r_pad) - 5'd1))
        else $error("padding count did not step down");

    a_result_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_finish |=> (r_out_valid && !r_fin && r_acc == '0))
        else $error("finish did not load the result and clear the accumulator");

endmodule
